// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL; clock clk, synchronous active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tbzsa_pkg.sv
// Package: constants, codes and request/response types of the zone state allocator.
package tbzsa_pkg;

  localparam int NUM_ZONES      = 1024;
  localparam int RESERVED_ZONES = 4;

  localparam int ID_W       = 10;
  localparam int ENT_W      = 2;
  localparam int LANES      = 4;
  localparam int WORD_W     = LANES * ENT_W;
  localparam int ID_LIMIT   = 1 << ID_W;
  localparam int ZONE_SPAN  = (NUM_ZONES < ID_LIMIT) ? NUM_ZONES : ID_LIMIT;
  localparam int WORDS      = (ZONE_SPAN + LANES - 1) / LANES;
  localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int START_WORD = RESERVED_ZONES / LANES;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [ENT_W-1:0] ENT_FREE = 2'd0;
  localparam logic [ENT_W-1:0] ENT_FILE = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [ID_W-1:0]  zone_id;
    logic [ENT_W-1:0] new_state;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]  result_id;
    logic [ENT_W-1:0] entry_state;
    logic [1:0]       status;
  } rsp_t;

endpackage

// File: rtl/core/two_bit_zone_state_allocator_unit.sv
// Zone state allocator: 2-bit states packed four per memory word, first-fit allocate.
// Query/free go through S_LOOK; reserved or out-of-range ids skip it; allocate scans in S_SCAN.
// Allocate reads one 4-entry word per cycle: up to 255 words at 1024 zones.
// One request in flight; next request accepted while a response waits in the output register.
// rst_n (sync, active low) clears control and per-word valid bits; no memory clearing pass.
module two_bit_zone_state_allocator_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tbzsa_pkg::req_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tbzsa_pkg::rsp_t   out_data
);
  import tbzsa_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam logic [ID_W:0]      RES_ID    = (ID_W+1)'(RESERVED_ZONES);
  localparam logic [ID_W:0]      END_ID    = (ID_W+1)'(ZONE_SPAN);
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);
  localparam logic [WORD_AW-1:0] FIRST_WD  = WORD_AW'(START_WORD);

  state_t               state_r, state_nxt;
  req_t                 req_r, req_nxt;
  rsp_t                 res_r, res_nxt;
  rsp_t                 out_data_r, out_data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_AW-1:0]   scan_addr_r, scan_addr_nxt;
  logic [WORD_AW-1:0]   chk_addr_r, chk_addr_nxt;
  logic                 chk_vld_r, chk_vld_nxt;

  logic [WORD_W-1:0]    mem [WORDS];
  logic [WORDS-1:0]     row_vld_r;
  logic [WORD_W-1:0]    rd_data_r;
  logic                 rd_vld_r;
  logic [WORD_AW-1:0]   rd_addr;
  logic                 wr_en;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_W-1:0]    wr_data;

  logic [WORD_W-1:0]    word_eff;
  logic [LANES-1:0]     lane_free;
  logic                 hit;
  logic [1:0]           hit_lane;
  logic [ID_W:0]        in_id;
  logic [1:0]           req_lane;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign word_eff  = rd_vld_r ? rd_data_r : '0;
  assign in_id     = {1'b0, in_data.zone_id};
  assign req_lane  = req_r.zone_id[1:0];

  always_comb begin
    logic [ID_W:0] lid;
    lid = '0;
    for (int j = 0; j < LANES; j++) begin
      lid = {1'b0, ID_W'({chk_addr_r, 2'(j)})};
      lane_free[j] = (lid >= RES_ID) && (lid < END_ID) &&
                     (word_eff[j*ENT_W +: ENT_W] == ENT_FREE);
    end
  end

  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      if (lane_free[j]) begin
        hit      = 1'b1;
        hit_lane = 2'(j);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    scan_addr_nxt = scan_addr_r;
    chk_addr_nxt  = chk_addr_r;
    chk_vld_nxt   = chk_vld_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_addr       = scan_addr_r;
    wr_en         = 1'b0;
    wr_addr       = chk_addr_r;
    wr_data       = word_eff;
    case (state_r)
      S_IDLE: begin
        rd_addr = WORD_AW'(in_data.zone_id >> 2);
        if (in_valid) begin
          req_nxt = in_data;
          if (in_data.opcode == OP_ALLOC) begin
            scan_addr_nxt = FIRST_WD;
            chk_vld_nxt   = 1'b0;
            state_nxt     = S_SCAN;
          end else if (in_id < RES_ID) begin
            res_nxt   = '{result_id: in_data.zone_id, entry_state: ENT_FILE,
                          status: (in_data.opcode == OP_FREE) ? ST_REFUSED : ST_OK};
            state_nxt = S_DONE;
          end else if (in_id >= END_ID) begin
            res_nxt   = '{result_id: in_data.zone_id, entry_state: ENT_FREE, status: ST_OK};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (req_r.opcode == OP_FREE) begin
          wr_en   = 1'b1;
          wr_addr = WORD_AW'(req_r.zone_id >> 2);
          wr_data[{req_lane, 1'b0} +: ENT_W] = ENT_FREE;
          res_nxt = '{result_id: req_r.zone_id, entry_state: ENT_FREE, status: ST_OK};
        end else begin
          res_nxt = '{result_id: req_r.zone_id,
                      entry_state: word_eff[{req_lane, 1'b0} +: ENT_W], status: ST_OK};
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (scan_addr_r != LAST_WORD) begin
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
        chk_addr_nxt = scan_addr_r;
        chk_vld_nxt  = 1'b1;
        if (chk_vld_r) begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_addr = chk_addr_r;
            wr_data[{hit_lane, 1'b0} +: ENT_W] = req_r.new_state;
            res_nxt = '{result_id: ID_W'({chk_addr_r, hit_lane}),
                        entry_state: req_r.new_state, status: ST_OK};
            state_nxt = S_DONE;
          end else if (chk_addr_r == LAST_WORD) begin
            res_nxt   = '{result_id: '0, entry_state: ENT_FREE, status: ST_FULL};
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
  end

  // state memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= row_vld_r[rd_addr];
  end

  `ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, state_r != S_IDLE, "request accepted but still idle")
  `ASSERT_IMP(a_full_zero, out_valid_r && out_data_r.status == ST_FULL, out_data_r.result_id == '0 && out_data_r.entry_state == ENT_FREE, "full response carries data")
  `ASSERT_IMP(a_refused_reserved, out_valid_r && out_data_r.status == ST_REFUSED, {1'b0, out_data_r.result_id} < RES_ID, "refusal for non-reserved id")
  `ASSERT_IMP(a_write_state, wr_en, state_r == S_LOOK || state_r == S_SCAN, "memory write outside lookup or scan")

endmodule

// File: tb/sv/tbzsa_checker.sv
// Response checker for the zone state allocator: tracks the zone table and compares responses.
`timescale 1ns / 100ps
module tbzsa_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  tbzsa_pkg::req_t in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  tbzsa_pkg::rsp_t out_data,
  output int              fail_count,
  output int              pending
);
  import tbzsa_pkg::*;

  logic [ENT_W-1:0] zone_tbl [NUM_ZONES];
  rsp_t             exp_rsp_q [$];
  rsp_t             want;
  int               mism_n = 0;

  function automatic logic [ENT_W-1:0] zone_read(int id);
    if (id < RESERVED_ZONES) return ENT_FILE;
    if (id >= NUM_ZONES) return ENT_FREE;
    return zone_tbl[id];
  endfunction

  function automatic void zone_write(int id, logic [ENT_W-1:0] code);
    if (id >= RESERVED_ZONES && id < NUM_ZONES) zone_tbl[id] = code;
  endfunction

  function automatic rsp_t apply_zone_op(req_t rq);
    rsp_t rs;
    int   k;
    bit   found;
    rs.result_id   = rq.zone_id;
    rs.entry_state = ENT_FREE;
    rs.status      = ST_OK;
    case (rq.opcode)
      OP_ALLOC: begin
        rs.result_id = '0;
        rs.status    = ST_FULL;
        found        = 1'b0;
        for (k = RESERVED_ZONES; k < ZONE_SPAN && !found; k++) begin
          if (zone_read(k) == ENT_FREE) begin
            zone_write(k, rq.new_state);
            rs.result_id   = ID_W'(k);
            rs.entry_state = rq.new_state;
            rs.status      = ST_OK;
            found          = 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (rq.zone_id < RESERVED_ZONES) begin
          rs.entry_state = ENT_FILE;
          rs.status      = ST_REFUSED;
        end else begin
          zone_write(rq.zone_id, ENT_FREE);
          rs.entry_state = zone_read(rq.zone_id);
        end
      end
      default: rs.entry_state = zone_read(rq.zone_id);
    endcase
    return rs;
  endfunction

  function automatic int field_miss(string fname, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (zone_tbl[i]) zone_tbl[i] = ENT_FREE;
      exp_rsp_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (exp_rsp_q.size() == 0) begin
          $display("%0t: unexpected response: expected none, got id %0d state %0d status %0d",
                   $time, out_data.result_id, out_data.entry_state, out_data.status);
          mism_n++;
        end else begin
          want = exp_rsp_q.pop_front();
          mism_n += field_miss("result_id", 16'(want.result_id), 16'(out_data.result_id));
          mism_n += field_miss("entry_state", 16'(want.entry_state),
                               16'(out_data.entry_state));
          mism_n += field_miss("status", 16'(want.status), 16'(out_data.status));
        end
      end
      if (in_valid && in_ready) exp_rsp_q.push_back(apply_zone_op(in_data));
    end
    fail_count <= mism_n;
    pending    <= exp_rsp_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the zone state allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import tbzsa_pkg::*;

  localparam logic [1:0] OP_QUERY_ALT = 2'd3;
  localparam int IDLE_MAX     = 8;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic out_valid;
  logic out_ready;
  req_t in_data;
  rsp_t out_data;
  int   fail_count;
  int   pending;
  bit   tx_idle  = 1'b0;
  bit   rx_idle  = 1'b0;
  bit   hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  two_bit_zone_state_allocator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  tbzsa_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic send_zone_req(logic [1:0] op, int id, int ns);
    int   gap;
    req_t rq;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rq.opcode    = op;
    rq.zone_id   = ID_W'(id);
    rq.new_state = ENT_W'(ns);
    in_data  <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_all_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_mixed_reqs(int n, int hold_at);
    int         i;
    int         pick;
    int         id;
    logic [1:0] op;
    for (i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        tx_idle = 1'($urandom_range(0, 1));
        rx_idle = 1'($urandom_range(0, 1));
      end
      // long output stall with the sender streaming back to back
      if (i == hold_at) begin
        hold_req = 1'b1;
        tx_idle  = 1'b0;
      end
      pick = $urandom_range(0, 99);
      id   = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 127) : $urandom_range(0, 1023);
      if (pick < 35) op = OP_ALLOC;
      else if (pick < 65) op = OP_FREE;
      else if (pick < 95) op = OP_QUERY;
      else op = OP_QUERY_ALT;
      send_zone_req(op, id, $urandom_range(0, 3));
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int i;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reserved ids, table edges, alloc state codes, reuse of freed ids
    send_zone_req(OP_QUERY, 0, 0);
    send_zone_req(OP_QUERY, 3, 3);
    send_zone_req(OP_QUERY, 4, 0);
    send_zone_req(OP_QUERY, 1023, 3);
    send_zone_req(OP_QUERY_ALT, 2, 1);
    send_zone_req(OP_FREE, 0, 0);
    send_zone_req(OP_FREE, 3, 2);
    send_zone_req(OP_FREE, 1023, 0);
    send_zone_req(OP_ALLOC, 0, 1);
    send_zone_req(OP_ALLOC, 1023, 2);
    send_zone_req(OP_ALLOC, 512, 3);
    send_zone_req(OP_ALLOC, 0, 0);
    send_zone_req(OP_ALLOC, 0, 1);
    send_zone_req(OP_QUERY, 4, 0);
    send_zone_req(OP_QUERY, 5, 0);
    send_zone_req(OP_QUERY_ALT, 6, 0);
    send_zone_req(OP_QUERY, 7, 0);
    send_zone_req(OP_FREE, 5, 3);
    send_zone_req(OP_QUERY, 5, 0);
    send_zone_req(OP_ALLOC, 341, 2);
    send_zone_req(OP_ALLOC, 682, 3);
    send_zone_req(OP_FREE, 4, 3);
    send_zone_req(OP_QUERY, 1020, 0);
    wait_all_responses();

    send_mixed_reqs(40, 20);
    wait_all_responses();

    // fill the whole table, then hit the full condition
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    for (i = 0; i < NUM_ZONES - RESERVED_ZONES; i++)
      send_zone_req(OP_ALLOC, $urandom_range(0, 1023), $urandom_range(1, 3));
    tx_idle = 1'b1;
    for (i = 0; i < 6; i++)
      send_zone_req(OP_ALLOC, $urandom_range(0, 1023), $urandom_range(0, 3));
    send_zone_req(OP_FREE, 900, 0);
    send_zone_req(OP_FREE, 4, 0);
    send_zone_req(OP_FREE, 1023, 0);
    send_zone_req(OP_ALLOC, 0, 2);
    send_zone_req(OP_ALLOC, 0, 0);
    send_zone_req(OP_ALLOC, 0, 3);
    send_zone_req(OP_ALLOC, 0, 1);
    send_zone_req(OP_ALLOC, 0, 1);
    send_zone_req(OP_ALLOC, 0, 2);

    send_mixed_reqs(40, -1);
    wait_all_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tbzsa_pkg.sv
rtl/core/two_bit_zone_state_allocator_unit.sv
tb/sv/tbzsa_checker.sv
tb/sv/tb_top.sv
